FILE: rtl/sot_pkg.sv
// ----------------------------------------------------------------------------
// sot_pkg: shared types, constants and tables of the shape tessellator
// Sine quarter-wave ROM, secant table for polygon inset, angle step tables,
// and the command/status records between the controller and the datapath.
// ----------------------------------------------------------------------------
package sot_pkg;

  localparam int MaxSides      = 16;
  localparam int SineTableBits = 10;
  localparam int QtrEntries    = 1 << (SineTableBits - 2);
  localparam int RomIdxW       = SineTableBits - 1;
  localparam int CntW          = $clog2(MaxSides + 2);
  localparam int CoordW        = 32;
  localparam int TrigW         = 18;
  localparam int ProdW         = TrigW + CoordW;
  localparam int SecW          = 33;

  localparam longint unsigned PiQ30     = 64'd3373259426;
  localparam longint unsigned PiHalfQ30 = 64'd1686629713;

  typedef logic [16:0]       sine_rom_t [QtrEntries + 1];
  typedef logic [SecW-1:0]   sec_tab_t  [MaxSides + 1];
  typedef logic [15:0]       quot_tab_t [MaxSides + 1];
  typedef logic [CntW-1:0]   rem_tab_t  [MaxSides + 1];

  // Q30 Taylor series of sine, terms truncated as they are formed
  function automatic longint unsigned sin_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint          acc;
    x2  = (x * x) >> 30;
    t   = x;
    acc = longint'(x);
    t = ((t * x2) >> 30) / 6;   acc = acc - longint'(t);
    t = ((t * x2) >> 30) / 20;  acc = acc + longint'(t);
    t = ((t * x2) >> 30) / 42;  acc = acc - longint'(t);
    t = ((t * x2) >> 30) / 72;  acc = acc + longint'(t);
    t = ((t * x2) >> 30) / 110; acc = acc - longint'(t);
    t = ((t * x2) >> 30) / 156; acc = acc + longint'(t);
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    return longint'(acc);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned x;
    for (int k = 0; k <= QtrEntries; k++) begin
      x      = (longint'(k) * PiHalfQ30) >> (SineTableBits - 2);
      rom[k] = 17'((sin_q30(x) + 64'd8192) >> 14);
    end
    return rom;
  endfunction

  // cos(pi/N) in Q30, one per legal side count
  localparam longint unsigned CosQ30N3  = sin_q30(PiHalfQ30 - PiQ30 / 64'd3);
  localparam longint unsigned CosQ30N4  = sin_q30(PiHalfQ30 - PiQ30 / 64'd4);
  localparam longint unsigned CosQ30N5  = sin_q30(PiHalfQ30 - PiQ30 / 64'd5);
  localparam longint unsigned CosQ30N6  = sin_q30(PiHalfQ30 - PiQ30 / 64'd6);
  localparam longint unsigned CosQ30N7  = sin_q30(PiHalfQ30 - PiQ30 / 64'd7);
  localparam longint unsigned CosQ30N8  = sin_q30(PiHalfQ30 - PiQ30 / 64'd8);
  localparam longint unsigned CosQ30N9  = sin_q30(PiHalfQ30 - PiQ30 / 64'd9);
  localparam longint unsigned CosQ30N10 = sin_q30(PiHalfQ30 - PiQ30 / 64'd10);
  localparam longint unsigned CosQ30N11 = sin_q30(PiHalfQ30 - PiQ30 / 64'd11);
  localparam longint unsigned CosQ30N12 = sin_q30(PiHalfQ30 - PiQ30 / 64'd12);
  localparam longint unsigned CosQ30N13 = sin_q30(PiHalfQ30 - PiQ30 / 64'd13);
  localparam longint unsigned CosQ30N14 = sin_q30(PiHalfQ30 - PiQ30 / 64'd14);
  localparam longint unsigned CosQ30N15 = sin_q30(PiHalfQ30 - PiQ30 / 64'd15);
  localparam longint unsigned CosQ30N16 = sin_q30(PiHalfQ30 - PiQ30 / 64'd16);

  localparam sine_rom_t SineRom  = build_sine_rom();

  // secant in Q30, zero below three sides
  localparam sec_tab_t  SecTab   = '{
    SecW'(0), SecW'(0), SecW'(0),
    SecW'((64'd1 << 60) / CosQ30N3),  SecW'((64'd1 << 60) / CosQ30N4),
    SecW'((64'd1 << 60) / CosQ30N5),  SecW'((64'd1 << 60) / CosQ30N6),
    SecW'((64'd1 << 60) / CosQ30N7),  SecW'((64'd1 << 60) / CosQ30N8),
    SecW'((64'd1 << 60) / CosQ30N9),  SecW'((64'd1 << 60) / CosQ30N10),
    SecW'((64'd1 << 60) / CosQ30N11), SecW'((64'd1 << 60) / CosQ30N12),
    SecW'((64'd1 << 60) / CosQ30N13), SecW'((64'd1 << 60) / CosQ30N14),
    SecW'((64'd1 << 60) / CosQ30N15), SecW'((64'd1 << 60) / CosQ30N16)
  };

  // quotient and remainder of a full turn over N
  localparam quot_tab_t QuotTab  = '{
    16'd0, 16'd0, 16'd0,
    16'(65536 / 3),  16'(65536 / 4),  16'(65536 / 5),  16'(65536 / 6),
    16'(65536 / 7),  16'(65536 / 8),  16'(65536 / 9),  16'(65536 / 10),
    16'(65536 / 11), 16'(65536 / 12), 16'(65536 / 13), 16'(65536 / 14),
    16'(65536 / 15), 16'(65536 / 16)
  };

  localparam rem_tab_t  RemTab   = '{
    CntW'(0), CntW'(0), CntW'(0),
    CntW'(65536 % 3),  CntW'(65536 % 4),  CntW'(65536 % 5),  CntW'(65536 % 6),
    CntW'(65536 % 7),  CntW'(65536 % 8),  CntW'(65536 % 9),  CntW'(65536 % 10),
    CntW'(65536 % 11), CntW'(65536 % 12), CntW'(65536 % 13), CntW'(65536 % 14),
    CntW'(65536 % 15), CntW'(65536 % 16)
  };

  typedef enum logic [2:0] {
    TRI_FAN_OUT,
    TRI_FAN_IN,
    TRI_RING_A,
    TRI_RING_B,
    TRI_NOGEO
  } tri_sel_e;

  typedef struct packed {
    logic     capture;
    logic     setup_a;
    logic     setup_b;
    logic     setup_c;
    logic     pass_start;
    logic     pt_ang;
    logic     pt_mul;
    logic     pt_wr;
    logic     load;
    tri_sel_e tri_sel;
    logic     mesh;
    logic     last;
  } sot_cmd_t;

  typedef struct packed {
    logic valid;
    logic collapsed;
    logic outl_act;
    logic fill;
    logic first_vtx;
    logic pass_done;
    logic out_free;
  } sot_stat_t;

endpackage

FILE: rtl/sot_dp.sv
// ----------------------------------------------------------------------------
// sot_dp: tessellator datapath
// Command capture, setup arithmetic, vertex generator and output register.
// ----------------------------------------------------------------------------
module sot_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [151:0]        in_tdata_i,
  input  logic                in_tuser_i,
  input  sot_pkg::sot_cmd_t   cmd_i,
  output sot_pkg::sot_stat_t  stat_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [191:0]        m_tdata_o,
  output logic [1:0]          m_tuser_o,
  output logic                m_tlast_o
);

  localparam int B  = sot_pkg::SineTableBits;
  localparam int NW = sot_pkg::CntW;
  localparam int RomIdxWL = sot_pkg::RomIdxW;

  // captured command
  logic        kind_q, fill_q, outl_q;
  logic [31:0] sx_q, sy_q, rad_q, wid_q;
  logic [4:0]  vc_q;
  logic [15:0] start_q;

  // setup results
  logic [30:0]   hw_q, hh_q, r_q, w_q, iw_q, ih_q, inner_q;
  logic [NW-1:0] n_q;
  logic [63:0]   prod_q;

  // vertex generator
  logic [NW-1:0]                   v_q, rem_q;
  logic [16:0]                     acc_q;
  logic signed [sot_pkg::TrigW-1:0] cos_q, sin_q;
  logic signed [sot_pkg::ProdW-1:0] pxo_q, pyo_q, pxi_q, pyi_q;
  logic [31:0] cox_q, coy_q, cix_q, ciy_q, pox_q, poy_q, pix_q, piy_q;

  logic out_valid_q;

  function automatic logic [30:0] mag(input logic [31:0] v);
    logic [31:0] n;
    n = -v;
    if (!v[31])               return v[30:0];
    else if (v == 32'h8000_0000) return 31'h7FFF_FFFF;
    else                      return n[30:0];
  endfunction

  function automatic logic signed [sot_pkg::TrigW-1:0] trig(input logic [B-1:0] idx);
    logic [B-3:0]   rr;
    logic [16:0]    e;
    logic [RomIdxWL-1:0] ri;
    rr = idx[B-3:0];
    ri = RomIdxWL'(sot_pkg::QtrEntries) - {1'b0, rr};
    e  = idx[B-2] ? sot_pkg::SineRom[ri] : sot_pkg::SineRom[{1'b0, rr}];
    return idx[B-1] ? -$signed({1'b0, e}) : $signed({1'b0, e});
  endfunction

  function automatic logic [31:0] rnd(input logic signed [sot_pkg::ProdW-1:0] p);
    logic signed [sot_pkg::ProdW-1:0] v;
    v = p + sot_pkg::ProdW'(32768);
    return v[47:16];
  endfunction

  // combinational helpers
  logic [15:0]   angle;
  logic [B-1:0]  sidx, cidx;
  logic [32:0]   dw, dh;
  logic [34:0]   shrink;
  logic signed [35:0] inner_s;
  logic [NW:0]   rem_sum;
  logic [1:0]    corner;
  logic          negx, negy;
  logic signed [31:0] r_s, in_s;
  logic [30:0]   mag_x, mag_y;

  assign angle   = start_q + acc_q[15:0];
  assign sidx    = angle[15 -: B];
  assign cidx    = sidx + B'(sot_pkg::QtrEntries);
  assign dw      = {2'b0, hw_q} - {2'b0, w_q};
  assign dh      = {2'b0, hh_q} - {2'b0, w_q};
  assign shrink  = 35'((prod_q + 64'd536870912) >> 30);
  assign inner_s = $signed({5'b0, r_q}) - $signed({1'b0, shrink});
  assign rem_sum = {1'b0, rem_q} + {1'b0, sot_pkg::RemTab[n_q]};
  assign corner  = v_q[1:0];
  assign negx    = (corner == 2'd0) || (corner == 2'd3);
  assign negy    = (corner == 2'd0) || (corner == 2'd1);
  assign r_s     = $signed({1'b0, r_q});
  assign in_s    = $signed({1'b0, inner_q});
  assign mag_x   = mag(sx_q);
  assign mag_y   = mag(sy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= in_tuser_i;
      sx_q    <= in_tdata_i[31:0];
      sy_q    <= in_tdata_i[63:32];
      rad_q   <= in_tdata_i[95:64];
      vc_q    <= in_tdata_i[100:96];
      start_q <= in_tdata_i[116:101];
      fill_q  <= in_tdata_i[117];
      outl_q  <= in_tdata_i[118];
      wid_q   <= in_tdata_i[150:119];
    end
    if (cmd_i.setup_a) begin
      hw_q <= {1'b0, mag_x[30:1]};
      hh_q <= {1'b0, mag_y[30:1]};
      r_q  <= mag(rad_q);
      w_q  <= (outl_q && !wid_q[31]) ? wid_q[30:0] : 31'd0;
      if (!kind_q)                      n_q <= NW'(4);
      else if (vc_q > 5'(sot_pkg::MaxSides)) n_q <= NW'(sot_pkg::MaxSides);
      else                              n_q <= NW'(vc_q);
    end
    if (cmd_i.setup_b) begin
      prod_q <= {33'b0, w_q} * {31'b0, sot_pkg::SecTab[n_q]};
      iw_q   <= dw[32] ? 31'd0 : dw[30:0];
      ih_q   <= dh[32] ? 31'd0 : dh[30:0];
    end
    if (cmd_i.setup_c) begin
      inner_q <= inner_s[35] ? 31'd0 : inner_s[30:0];
    end
    if (cmd_i.pt_ang) begin
      cos_q <= trig(cidx);
      sin_q <= trig(sidx);
    end
    if (cmd_i.pt_mul) begin
      pxo_q <= cos_q * r_s;
      pyo_q <= sin_q * r_s;
      pxi_q <= cos_q * in_s;
      pyi_q <= sin_q * in_s;
    end
    if (cmd_i.pt_wr) begin
      pox_q <= cox_q; poy_q <= coy_q;
      pix_q <= cix_q; piy_q <= ciy_q;
      if (kind_q) begin
        cox_q <= rnd(pxo_q); coy_q <= rnd(pyo_q);
        cix_q <= rnd(pxi_q); ciy_q <= rnd(pyi_q);
      end else begin
        cox_q <= negx ? -{1'b0, hw_q} : {1'b0, hw_q};
        coy_q <= negy ? -{1'b0, hh_q} : {1'b0, hh_q};
        cix_q <= negx ? -{1'b0, iw_q} : {1'b0, iw_q};
        ciy_q <= negy ? -{1'b0, ih_q} : {1'b0, ih_q};
      end
    end
  end

  // vertex counter and angle accumulator (exact floor(i*65536/N))
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      rem_q <= '0;
      acc_q <= '0;
    end else if (cmd_i.pass_start) begin
      v_q   <= '0;
      rem_q <= '0;
      acc_q <= '0;
    end else if (cmd_i.pt_wr) begin
      v_q <= v_q + NW'(1);
      if (rem_sum >= {1'b0, n_q}) begin
        rem_q <= NW'(rem_sum - {1'b0, n_q});
        acc_q <= acc_q + {1'b0, sot_pkg::QuotTab[n_q]} + 17'd1;
      end else begin
        rem_q <= NW'(rem_sum);
        acc_q <= acc_q + {1'b0, sot_pkg::QuotTab[n_q]};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_tlast_o <= cmd_i.last;
      m_tuser_o <= {1'b0, cmd_i.mesh};
      case (cmd_i.tri_sel)
        sot_pkg::TRI_FAN_OUT: m_tdata_o <= {coy_q, cox_q, poy_q, pox_q, 64'd0};
        sot_pkg::TRI_FAN_IN:  m_tdata_o <= {ciy_q, cix_q, piy_q, pix_q, 64'd0};
        sot_pkg::TRI_RING_A:  m_tdata_o <= {ciy_q, cix_q, piy_q, pix_q, poy_q, pox_q};
        sot_pkg::TRI_RING_B:  m_tdata_o <= {coy_q, cox_q, ciy_q, cix_q, poy_q, pox_q};
        default: begin
          m_tdata_o <= '0;
          m_tuser_o <= 2'b10;
        end
      endcase
    end
  end

  assign m_tvalid_o = out_valid_q;

  assign stat_o.valid     = kind_q ? ((r_q != 31'd0) && (n_q >= NW'(3)))
                                   : ((hw_q != 31'd0) && (hh_q != 31'd0));
  assign stat_o.collapsed = kind_q ? (inner_q == 31'd0)
                                   : ((iw_q == 31'd0) || (ih_q == 31'd0));
  assign stat_o.outl_act  = (w_q != 31'd0);
  assign stat_o.fill      = fill_q;
  assign stat_o.first_vtx = (v_q == '0);
  assign stat_o.pass_done = (v_q > n_q);
  assign stat_o.out_free  = !out_valid_q || m_tready_i;

endmodule

FILE: rtl/sot_ctrl.sv
// ----------------------------------------------------------------------------
// sot_ctrl: tessellator sequencer
// Runs setup, then one or two vertex passes, issuing triangle loads.
// ----------------------------------------------------------------------------
module sot_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_tvalid_i,
  output logic               in_tready_o,
  input  sot_pkg::sot_stat_t stat_i,
  output sot_pkg::sot_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SET_A, ST_SET_B, ST_SET_C, ST_PLAN,
    ST_PT_ANG, ST_PT_MUL, ST_PT_WR, ST_EMIT_A, ST_EMIT_B, ST_NO_GEO
  } state_e;

  typedef enum logic [1:0] {
    PASS_FAN_OUT, PASS_RING, PASS_FAN_IN
  } pass_e;

  state_e state_q;
  pass_e  pass_q;
  logic   mesh_q, final_q;

  assign in_tready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.tri_sel    = sot_pkg::TRI_NOGEO;
    cmd_o.mesh       = mesh_q;
    cmd_o.capture    = in_tvalid_i && (state_q == ST_IDLE);
    cmd_o.setup_a    = (state_q == ST_SET_A);
    cmd_o.setup_b    = (state_q == ST_SET_B);
    cmd_o.setup_c    = (state_q == ST_SET_C);
    cmd_o.pt_ang     = (state_q == ST_PT_ANG);
    cmd_o.pt_mul     = (state_q == ST_PT_MUL);
    cmd_o.pt_wr      = (state_q == ST_PT_WR);
    case (state_q)
      ST_PLAN: cmd_o.pass_start = 1'b1;
      ST_EMIT_A: begin
        cmd_o.load = stat_i.out_free;
        case (pass_q)
          PASS_RING:   cmd_o.tri_sel = sot_pkg::TRI_RING_A;
          PASS_FAN_IN: cmd_o.tri_sel = sot_pkg::TRI_FAN_IN;
          default:     cmd_o.tri_sel = sot_pkg::TRI_FAN_OUT;
        endcase
        cmd_o.last = final_q && (pass_q != PASS_RING) && stat_i.pass_done;
      end
      ST_EMIT_B: begin
        cmd_o.load       = stat_i.out_free;
        cmd_o.tri_sel    = sot_pkg::TRI_RING_B;
        cmd_o.last       = final_q && stat_i.pass_done;
        cmd_o.pass_start = stat_i.out_free && stat_i.pass_done && !final_q;
      end
      ST_NO_GEO: begin
        cmd_o.load = stat_i.out_free;
        cmd_o.mesh = 1'b0;
        cmd_o.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= PASS_FAN_OUT;
      mesh_q  <= 1'b0;
      final_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE:  if (in_tvalid_i) state_q <= ST_SET_A;
        ST_SET_A: state_q <= ST_SET_B;
        ST_SET_B: state_q <= ST_SET_C;
        ST_SET_C: state_q <= ST_PLAN;
        ST_PLAN: begin
          if (!stat_i.valid || (!stat_i.outl_act && !stat_i.fill)) begin
            state_q <= ST_NO_GEO;
          end else begin
            state_q <= ST_PT_ANG;
            if (stat_i.outl_act && !stat_i.collapsed) begin
              pass_q  <= PASS_RING;
              mesh_q  <= 1'b1;
              final_q <= !stat_i.fill;
            end else begin
              pass_q  <= PASS_FAN_OUT;
              mesh_q  <= stat_i.outl_act;
              final_q <= 1'b1;
            end
          end
        end
        ST_PT_ANG: state_q <= ST_PT_MUL;
        ST_PT_MUL: state_q <= ST_PT_WR;
        ST_PT_WR:  state_q <= stat_i.first_vtx ? ST_PT_ANG : ST_EMIT_A;
        ST_EMIT_A: begin
          if (stat_i.out_free) begin
            if (pass_q == PASS_RING)   state_q <= ST_EMIT_B;
            else if (stat_i.pass_done) state_q <= ST_IDLE;
            else                       state_q <= ST_PT_ANG;
          end
        end
        ST_EMIT_B: begin
          if (stat_i.out_free) begin
            if (stat_i.pass_done && final_q) begin
              state_q <= ST_IDLE;
            end else if (stat_i.pass_done) begin
              pass_q  <= PASS_FAN_IN;
              mesh_q  <= 1'b0;
              final_q <= 1'b1;
              state_q <= ST_PT_ANG;
            end else begin
              state_q <= ST_PT_ANG;
            end
          end
        end
        ST_NO_GEO: if (stat_i.out_free) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/shape_outline_fill_tessellator.sv
// ----------------------------------------------------------------------------
// shape_outline_fill_tessellator: rectangle / regular polygon to triangles
// One shape command in, up to 48 triangles out (outline ring, then fill fan).
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                          | tuser / tlast
//  ---------+-----+---------------------------------------------+----------------
//  s_axis   | in  | size_x, size_y, radius, vertex_count,       | tuser: kind
//           |     | start_angle, fill_enable, outline_enable,   |
//           |     | outline_width, 1 pad bit                    |
//  m_axis   | out | x_first, y_first, x_second, y_second,       | tuser: mesh_select,
//           |     | x_third, y_third                            | no_geometry; tlast
//
// Setup runs magnitudes, width x secant multiply and inset clamp in turn,
// then each generated vertex goes through angle/table read, multiply, round
// for N+1 vertices per pass, plus one triangle per vertex after the first
// (two per ring edge). The shared vertex generator forms one outer/inner
// vertex pair after the other, and a stalled emit holds it back.
// Reset clears the sequencer, the vertex counter and angle accumulator, and
// the output valid; no clearing pass. A stalled m_axis holds the sequencer
// in its emit state; the last triangle waits in the output register while the next command is already accepted.
//
module shape_outline_fill_tessellator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [151:0] s_axis_tdata,   // size_x, size_y, radius, vertex_count,
                                       // start_angle, fill_enable, outline_enable,
                                       // outline_width, pad
  input  logic         s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // x_first, y_first, x_second, y_second,
                                       // x_third, y_third
  output logic [1:0]   m_axis_tuser,   // mesh_select, no_geometry
  output logic         m_axis_tlast
);

  sot_pkg::sot_cmd_t  cmd;
  sot_pkg::sot_stat_t stat;

  sot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sot_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_tdata_i (s_axis_tdata),
    .in_tuser_i (s_axis_tuser),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule
